[hw/rtl/bvms_pkg.sv]
// bvms_pkg: shared types, register codes and the voxel rule for the 3D
// six-neighbor morphology stencil. No dependencies.
`timescale 1ns / 1ps

package bvms_pkg;

  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 7;
  localparam int unsigned ModeW         = 3;
  localparam int unsigned NumNbrs       = 6;
  localparam int unsigned CntW          = $clog2(NumNbrs + 1);
  localparam int unsigned MajorityLimit = 3;

  // output word buffer
  localparam int unsigned FifoDepth = 3;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_MODE   = 2'd3
  } reg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_ERODE    = 3'd0,
    MODE_DILATE   = 3'd1,
    MODE_MAJORITY = 3'd2,
    MODE_INVERT   = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  // one plane store entry: same position in the two most recent planes
  typedef struct packed {
    logic newer;
    logic older;
  } plane_word_t;

  // face neighbors of the center voxel
  typedef struct packed {
    logic xm;
    logic xp;
    logic ym;
    logic yp;
    logic zm;
    logic zp;
  } nbr_t;

  typedef struct packed {
    logic voxel_out;
    logic last_voxel;
  } result_t;

  function automatic logic apply_rule(logic [ModeW-1:0] mode, logic center,
                                      nbr_t nb_valid, nbr_t nb_val);
    logic [NumNbrs-1:0] vbits;
    logic [NumNbrs-1:0] dbits;
    logic [CntW-1:0]    black;
    logic [CntW-1:0]    white;
    logic               res;
    vbits = nb_valid;
    dbits = nb_val;
    black = '0;
    white = '0;
    for (int k = 0; k < NumNbrs; k++) begin
      black = black + CntW'(vbits[k] & dbits[k]);
      white = white + CntW'(vbits[k] & ~dbits[k]);
    end
    unique case (mode)
      MODE_ERODE:    res = (center && white != '0) ? 1'b0 : center;
      MODE_DILATE:   res = (!center && black != '0) ? 1'b1 : center;
      MODE_MAJORITY: begin
        if (center && white > CntW'(MajorityLimit)) res = 1'b0;
        else if (!center && black > CntW'(MajorityLimit)) res = 1'b1;
        else res = center;
      end
      MODE_INVERT:   res = ~center;
      MODE_CLEAR:    res = 1'b0;
      default:       res = center;
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/bvms_if.sv]
// bvms_if: valid/ready stream interfaces for input voxel words and result
// words. No dependencies.
`timescale 1ns / 1ps

interface bvms_in_if;
  logic valid;
  logic ready;
  logic voxel_in;
  logic drain;

  modport source (output valid, output voxel_in, output drain, input ready);
  modport sink   (input valid, input voxel_in, input drain, output ready);
endinterface

interface bvms_out_if;
  logic valid;
  logic ready;
  logic voxel_out;
  logic last_voxel;

  modport source (output valid, output voxel_out, output last_voxel, input ready);
  modport sink   (input valid, input voxel_out, input last_voxel, output ready);
endinterface

[hw/rtl/binary_volume_morphology_stencil.sv]
// binary_volume_morphology_stencil: streaming 3D binary morphology with a
// six-neighbor stencil over two planes held in the plane store.
// Depends on bvms_pkg, bvms_if, bvms_plane_mem, bvms_out_fifo.
//
//   channel   dir   fields                 handshake
//   in_ch     in    voxel_in, drain        valid/ready
//   out_ch    out   voxel_out, last_voxel  valid/ready
//   cfg       in    cfg_idx_i, cfg_data_i  cfg_we_i, no ready
//
// One word per cycle while in_ch.ready is high; results are registered in
// stage 1 and the result buffer. The rate is set by one read-modify-write
// of the plane store per word, the last write forwarded to the next reads.
// Reset clears counters and the pipeline; the plane store is not cleared.
// in_ch.ready drops only when the 3-entry result buffer backs up.
`timescale 1ns / 1ps

module binary_volume_morphology_stencil #(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bvms_in_if.sink                       in_ch,
  bvms_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [bvms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bvms_pkg::CfgDataW-1:0] cfg_data_i
);
  import bvms_pkg::*;

  localparam int unsigned Depth = MAX_Y * MAX_Z;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned XW    = $clog2(MAX_X + 1);
  localparam int unsigned YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int unsigned ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

  // configuration
  logic [CfgDataW-1:0] size_x_q, size_y_q, size_z_q;
  logic [ModeW-1:0]    mode_q;

  logic [XW-1:0] sx;
  logic [YW-1:0] sy_m1;
  logic [ZW-1:0] sz_m1;

  // position of the incoming word
  logic [XW-1:0]    x_q, x_d;
  logic [YW-1:0]    y_q, y_d;
  logic [ZW-1:0]    z_q, z_d;
  logic [AddrW-1:0] p_q, p_d;

  logic in_acc, in_vol, step, v, produce, z_end, y_end, last, size_wr;
  nbr_t nbv;

  logic [AddrW:0]   p_ext, sz_ext;
  logic [AddrW-1:0] addr_zp, addr_ym, addr_yp;

  // stage 1
  logic             s1_valid_q;
  logic             s1_prod_q;
  logic             s1_last_q;
  logic             s1_v_q;
  logic [AddrW-1:0] s1_addr_q;
  nbr_t             s1_nbv_q;
  logic             fwd_c_q, fwd_zp_q, fwd_ym_q, fwd_yp_q;
  plane_word_t      fwd_word_q;
  logic             prev_center_q;

  plane_word_t rd_a0, rd_a1, rd_b0, rd_b1;
  plane_word_t rd_c, rd_zp, rd_ym, rd_yp;
  plane_word_t wdata;
  logic        center;
  nbr_t        nbd;
  result_t     res;

  logic [FifoCntW-1:0] fifo_cnt;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 7'd64;
      size_y_q <= 7'd64;
      size_z_q <= 7'd64;
      mode_q   <= MODE_ERODE;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SIZE_X: size_x_q <= cfg_data_i;
        REG_SIZE_Y: size_y_q <= cfg_data_i;
        REG_SIZE_Z: size_z_q <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[ModeW-1:0];
      endcase
    end
  end

  assign size_wr = cfg_we_i && (cfg_idx_i != REG_MODE);

  always_comb begin
    if (size_x_q == '0) sx = XW'(1);
    else if (32'(size_x_q) > MAX_X) sx = XW'(MAX_X);
    else sx = XW'(size_x_q);

    if (size_y_q == '0) sy_m1 = '0;
    else if (32'(size_y_q) > MAX_Y) sy_m1 = YW'(MAX_Y - 1);
    else sy_m1 = YW'(size_y_q - 7'd1);

    if (size_z_q == '0) sz_m1 = '0;
    else if (32'(size_z_q) > MAX_Z) sz_m1 = ZW'(MAX_Z - 1);
    else sz_m1 = ZW'(size_z_q - 7'd1);
  end

  // ---------------------------------------------------------------- stage 0
  assign in_acc  = in_ch.valid & in_ch.ready;
  assign in_vol  = (x_q < sx);
  assign step    = in_acc & ~(in_vol & in_ch.drain);
  assign v       = in_vol & in_ch.voxel_in;
  assign produce = (x_q != '0);
  assign z_end   = (z_q == sz_m1);
  assign y_end   = (y_q == sy_m1);
  assign last    = (x_q == sx) & z_end & y_end;

  // neighbors of the center voxel (previous plane, same position)
  assign nbv.xm = (x_q > XW'(1));
  assign nbv.xp = in_vol;
  assign nbv.ym = (y_q != '0);
  assign nbv.yp = !y_end;
  assign nbv.zm = (z_q != '0);
  assign nbv.zp = !z_end;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    p_d = p_q;
    if (size_wr || (step && produce && last)) begin
      x_d = '0;
      y_d = '0;
      z_d = '0;
      p_d = '0;
    end else if (step) begin
      if (z_end) begin
        z_d = '0;
        if (y_end) begin
          y_d = '0;
          x_d = x_q + XW'(1);
        end else begin
          y_d = y_q + YW'(1);
        end
      end else begin
        z_d = z_q + ZW'(1);
      end
      p_d = (z_end && y_end) ? '0 : p_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
      p_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      p_q <= p_d;
    end
  end

  assign p_ext   = {1'b0, p_q};
  assign sz_ext  = (AddrW + 1)'(sz_m1) + (AddrW + 1)'(1);
  assign addr_zp = AddrW'(p_ext + (AddrW + 1)'(1));
  assign addr_ym = AddrW'(p_ext - sz_ext);
  assign addr_yp = AddrW'(p_ext + sz_ext);

  // two copies of the store give four reads per word
  bvms_plane_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem_a (
    .clk_i    (clk_i),
    .we_i     (s1_valid_q),
    .waddr_i  (s1_addr_q),
    .wdata_i  (wdata),
    .raddr0_i (p_q),
    .raddr1_i (addr_zp),
    .rdata0_o (rd_a0),
    .rdata1_o (rd_a1)
  );

  bvms_plane_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem_b (
    .clk_i    (clk_i),
    .we_i     (s1_valid_q),
    .waddr_i  (s1_addr_q),
    .wdata_i  (wdata),
    .raddr0_i (addr_ym),
    .raddr1_i (addr_yp),
    .rdata0_o (rd_b0),
    .rdata1_o (rd_b1)
  );

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_prod_q <= produce;
      s1_last_q <= last;
      s1_v_q    <= v;
      s1_addr_q <= p_q;
      s1_nbv_q  <= nbv;
    end
    // write of the word in stage 1 lands at this edge: forward it
    fwd_c_q    <= s1_valid_q && (p_q == s1_addr_q);
    fwd_zp_q   <= s1_valid_q && (addr_zp == s1_addr_q);
    fwd_ym_q   <= s1_valid_q && (addr_ym == s1_addr_q);
    fwd_yp_q   <= s1_valid_q && (addr_yp == s1_addr_q);
    fwd_word_q <= wdata;
    if (s1_valid_q) begin
      prev_center_q <= center;
    end
  end

  assign rd_c  = fwd_c_q  ? fwd_word_q : rd_a0;
  assign rd_zp = fwd_zp_q ? fwd_word_q : rd_a1;
  assign rd_ym = fwd_ym_q ? fwd_word_q : rd_b0;
  assign rd_yp = fwd_yp_q ? fwd_word_q : rd_b1;

  assign center = rd_c.newer;

  // entries behind the write position already hold the current plane
  assign nbd.xm = rd_c.older;
  assign nbd.xp = s1_v_q;
  assign nbd.ym = rd_ym.older;
  assign nbd.yp = rd_yp.newer;
  assign nbd.zm = prev_center_q;
  assign nbd.zp = rd_zp.newer;

  assign wdata.newer = s1_v_q;
  assign wdata.older = center;

  assign res.voxel_out  = apply_rule(mode_q, center, s1_nbv_q, nbd);
  assign res.last_voxel = s1_last_q;

  bvms_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q & s1_prod_q),
    .push_data_i (res),
    .count_o     (fifo_cnt),
    .out_ch      (out_ch)
  );

  assign in_ch.ready = ((FifoCntW + 1)'(fifo_cnt) + (FifoCntW + 1)'(s1_valid_q))
                       < (FifoCntW + 1)'(FifoDepth);

endmodule

[hw/rtl/bvms_plane_mem.sv]
// bvms_plane_mem: plane store, one write port and two registered read ports.
// Depends on bvms_pkg.
`timescale 1ns / 1ps

module bvms_plane_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  bvms_pkg::plane_word_t      wdata_i,
  input  logic [AddrW-1:0]           raddr0_i,
  input  logic [AddrW-1:0]           raddr1_i,
  output bvms_pkg::plane_word_t      rdata0_o,
  output bvms_pkg::plane_word_t      rdata1_o
);
  import bvms_pkg::*;

  plane_word_t mem_q [Depth];
  plane_word_t rdata0_q;
  plane_word_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-during-write returns the old entry; the caller forwards
  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

[hw/rtl/bvms_out_fifo.sv]
// bvms_out_fifo: small result word buffer in front of the output channel.
// Depends on bvms_pkg and bvms_if.
`timescale 1ns / 1ps

module bvms_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  bvms_pkg::result_t              push_data_i,
  output logic [bvms_pkg::FifoCntW-1:0]  count_o,
  bvms_out_if.source                     out_ch
);
  import bvms_pkg::*;

  result_t             buf_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d;
  logic [FifoPtrW-1:0] rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign pop = out_ch.valid & out_ch.ready;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + FifoPtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + FifoPtrW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

  assign out_ch.valid      = (cnt_q != '0);
  assign out_ch.voxel_out  = buf_q[rd_q].voxel_out;
  assign out_ch.last_voxel = buf_q[rd_q].last_voxel;
  assign count_o           = cnt_q;

endmodule

[hw/rtl/bvms_checker.sv]
// bvms_checker: port-level assertions for the morphology stencil, bound to
// the top level. Depends on bvms_if and binary_volume_morphology_stencil.
`timescale 1ns / 1ps

module bvms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  bvms_in_if.sink    in_ch,
  bvms_out_if.source out_ch
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.voxel_out) && $stable(out_ch.last_voxel))
    else $error("result word changed while stalled");

  // a drained output side never throttles the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_ch.ready) |-> in_ch.ready)
    else $error("input stalled with output ready");

  // a fresh result word needs an accepted input word before it
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !$past(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, 2))
    else $error("result word without an input word");

endmodule

bind binary_volume_morphology_stencil bvms_checker u_bvms_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
